// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
// All macros sample on the rising clock edge and stay quiet while reset is active.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every active clock edge
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: assertion failed");

// Same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// File: rtl/lmpf_pkg.sv
// Shared constants, types and the packet template for the level mapper framer.
// No dependencies; imported by every module of the block.
`default_nettype none

package lmpf_pkg;

    // Reading width and derived widths
    localparam int READING_BITS = 24;
    localparam int RW           = READING_BITS;
    localparam int XW           = READING_BITS + 1;
    localparam int LEVEL_W      = 7;
    localparam int QUOT_BITS    = 7;
    localparam int MUL_W        = RW + QUOT_BITS;
    localparam int QCNT_W       = $clog2(QUOT_BITS);

    // Packet layout
    localparam int PKT_LEN   = 43;
    localparam int IDX_W     = 6;
    localparam int LEVEL_POS = 11;
    localparam int CHK_POS   = 42;

    // Level constants
    localparam int LEVEL_FULL      = 125;
    localparam int LEVEL_TOP       = 120;
    localparam int LEVEL_CAL_FLOOR = 24;
    localparam int HYST            = 50;
    localparam int SHORTED         = -2;
    localparam logic [7:0] CHK_SEED = 8'hA0;

    // Register reset values
    localparam int MIN_RESET = 3000;
    localparam int MAX_RESET = 9000;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_READING     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_READING     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CALIBRATE_START = 2'd2;

    // Queue between front and framer
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_QW = $clog2(QDEPTH + 1);

    // One packet request: the mapped level and the calibration flag
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               cal;
    } frame_req_t;

    // Fixed packet template; level and checksum positions are overridden
    localparam logic [7:0] TMPL [0:PKT_LEN-1] = '{
        8'hFA, 8'h29, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h14, 8'h9A, 8'h00, 8'h00,
        8'h00, 8'h03, 8'h77, 8'h72, 8'h71, 8'h03, 8'h00, 8'h6C, 8'h4C, 8'h3B, 8'h03,
        8'h2F, 8'h15, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h21, 8'h00,
        8'h00, 8'h03, 8'hE8, 8'h00, 8'h2C, 8'h02, 8'h6D, 8'h37, 8'hD2, 8'h00
    };

endpackage

`default_nettype wire

// File: rtl/lmpf_front.sv
// Front end: accepts readings, runs the calibration update, maps to a level.
// Uses lmpf_pkg and assert_macros.svh; feeds lmpf_queue.
`default_nettype none
`include "assert_macros.svh"

module lmpf_front
    import lmpf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // reading input
    input  wire logic                  push,
    output logic                       full,
    input  wire logic signed [XW-1:0]  raw_reading,
    // configuration writes
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [RW-1:0]         cfg_data,
    // request queue
    output logic                       q_push,
    output frame_req_t                 q_item,
    input  wire logic                  q_full
);

    typedef enum logic [1:0] {F_IDLE, F_CLASS, F_DIV, F_PUSH} front_state_t;

    front_state_t        state_reg;
    logic [RW-1:0]       min_reg;
    logic [RW-1:0]       amax_reg;
    logic                cal_on_reg;
    logic [XW-1:0]       prev_reg;
    logic [XW-1:0]       x_reg;
    logic [MUL_W-1:0]    rem_reg;
    logic [MUL_W-1:0]    dvs_reg;
    logic [QUOT_BITS-1:0] quot_reg;
    logic [QCNT_W-1:0]   cnt_reg;
    logic [LEVEL_W-1:0]  level_reg;

    logic                accept;
    logic [XW:0]         prev_ext;
    logic [XW:0]         mn_ext;
    logic [XW:0]         peak_less;
    logic                cal_end;
    logic [RW-1:0]       amax_new;
    logic [XW:0]         diff;
    logic [RW:0]         span;
    logic                span_empty;
    logic                diff_neg;
    logic                diff_top;
    logic [LEVEL_W-1:0]  lo;
    logic [MUL_W-1:0]    product;
    logic                sub_ok;
    logic [QUOT_BITS-1:0] quot_step;
    logic                level_ok;

    assign accept = push && !full;
    assign full   = (state_reg != F_IDLE);

    // End-of-calibration detection at accept time
    always_comb
    begin
        prev_ext  = {prev_reg[XW-1], prev_reg};
        mn_ext    = {2'b00, min_reg};
        peak_less = prev_ext - (XW+1)'(HYST);
        cal_end   = cal_on_reg && (raw_reading == XW'(SHORTED))
                    && ($signed(prev_ext) > $signed(mn_ext));
        amax_new  = peak_less[XW] ? '0 : peak_less[RW-1:0];
    end

    // Classification of the latched reading
    always_comb
    begin
        diff       = {x_reg[XW-1], x_reg} - {2'b00, min_reg};
        span       = {1'b0, amax_reg} - {1'b0, min_reg};
        span_empty = span[RW] || (span == '0);
        diff_neg   = diff[XW];
        diff_top   = !diff_neg && (diff >= {1'b0, span});
        lo         = cal_on_reg ? LEVEL_W'(LEVEL_CAL_FLOOR) : '0;
        product    = MUL_W'(diff[RW-1:0]) * MUL_W'(LEVEL_TOP);
    end

    // One restoring-division step per cycle
    always_comb
    begin
        sub_ok    = (rem_reg >= dvs_reg);
        quot_step = {quot_reg[QUOT_BITS-2:0], sub_ok};
    end

    assign q_push       = (state_reg == F_PUSH) && !q_full;
    assign q_item.level = level_reg;
    assign q_item.cal   = cal_on_reg;

    // Level stays in range and above the floor while calibrating
    assign level_ok = (q_item.level <= LEVEL_W'(LEVEL_FULL))
                      && (!q_item.cal || (q_item.level >= LEVEL_W'(LEVEL_CAL_FLOOR)));

    // State machine, calibration state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            min_reg    <= RW'(MIN_RESET);
            amax_reg   <= RW'(MAX_RESET);
            cal_on_reg <= 1'b0;
            prev_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        x_reg    <= raw_reading;
                        prev_reg <= raw_reading;
                        if (cal_end)
                        begin
                            amax_reg   <= amax_new;
                            cal_on_reg <= 1'b0;
                        end
                        state_reg <= F_CLASS;
                    end
                end
                F_CLASS:
                begin
                    rem_reg  <= product;
                    dvs_reg  <= {1'b0, span[RW-1:0], {(QUOT_BITS-1){1'b0}}};
                    quot_reg <= '0;
                    cnt_reg  <= QCNT_W'(QUOT_BITS-1);
                    if (x_reg == XW'(SHORTED))
                    begin
                        level_reg <= LEVEL_W'(LEVEL_FULL);
                        state_reg <= F_PUSH;
                    end
                    else if (span_empty || diff_neg)
                    begin
                        level_reg <= lo;
                        state_reg <= F_PUSH;
                    end
                    else if (diff_top)
                    begin
                        level_reg <= LEVEL_W'(LEVEL_TOP);
                        state_reg <= F_PUSH;
                    end
                    else
                    begin
                        state_reg <= F_DIV;
                    end
                end
                F_DIV:
                begin
                    if (sub_ok)
                        rem_reg <= rem_reg - dvs_reg;
                    dvs_reg  <= dvs_reg >> 1;
                    quot_reg <= quot_step;
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        level_reg <= (quot_step < lo) ? lo : quot_step;
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (!q_full)
                        state_reg <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase

            // register writes must arrive only while idle; the block itself does not enforce this
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_MIN_READING:     min_reg    <= cfg_data;
                    REG_MAX_READING:     amax_reg   <= cfg_data;
                    REG_CALIBRATE_START: cal_on_reg <= cfg_data[0];
                    default:             ;
                endcase
            end
        end
    end

    `ASSERT_IMPLIES(a_level_range, clk, rst_n, q_push, level_ok)
    `ASSERT_NEXT(a_accept_class, clk, rst_n, accept, state_reg == F_CLASS)

endmodule

`default_nettype wire

// File: rtl/lmpf_queue.sv
// Two-entry request queue between the front end and the packet framer.
// Uses lmpf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lmpf_queue
    import lmpf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire frame_req_t  wr_data,
    output logic             q_full,
    input  wire logic        rd_en,
    output frame_req_t       rd_data,
    output logic             q_empty
);

    frame_req_t             mem_reg [0:QDEPTH-1];
    logic [QPTR_W-1:0]      wr_ptr_reg;
    logic [QPTR_W-1:0]      rd_ptr_reg;
    logic [QCNT_QW-1:0]     count_reg;

    assign q_full  = (count_reg == QCNT_QW'(QDEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // Storage write
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 1'b1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 1'b1;
        end
    end

    `ASSERT_IMPLIES(a_no_overflow, clk, rst_n, wr_en, !q_full)
    `ASSERT_IMPLIES(a_no_underflow, clk, rst_n, rd_en, !q_empty)

endmodule

`default_nettype wire

// File: rtl/lmpf_framer.sv
// Back end: builds the 43-byte packet for each queued level, one byte per word.
// Uses lmpf_pkg and assert_macros.svh; drains lmpf_queue.
`default_nettype none
`include "assert_macros.svh"

module lmpf_framer
    import lmpf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // request queue
    input  wire logic              q_empty,
    input  wire frame_req_t        q_data,
    output logic                   q_pop,
    // byte output
    output logic                   empty,
    input  wire logic              pop,
    output logic [7:0]             packet_byte,
    output logic [IDX_W-1:0]       byte_index,
    output logic                   last_byte,
    output logic                   calibrating
);

    logic                  busy_reg;
    logic [IDX_W-1:0]      cnt_reg;
    logic [LEVEL_W-1:0]    level_reg;
    logic                  cal_reg;
    logic [7:0]            chk_reg;
    logic                  out_valid_reg;
    logic [7:0]            byte_out_reg;
    logic [IDX_W-1:0]      idx_out_reg;
    logic                  last_out_reg;
    logic                  cal_out_reg;

    logic                  load;
    logic                  at_chk;
    logic [7:0]            cur_byte;

    assign load   = busy_reg && (!out_valid_reg || pop);
    assign q_pop  = !busy_reg && !q_empty;
    assign at_chk = (cnt_reg == IDX_W'(CHK_POS));

    // Byte select: level, checksum or template
    always_comb
    begin
        if (cnt_reg == IDX_W'(LEVEL_POS))
            cur_byte = {1'b0, level_reg};
        else if (at_chk)
            cur_byte = chk_reg;
        else
            cur_byte = TMPL[cnt_reg];
    end

    // Packet sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                busy_reg  <= 1'b1;
                cnt_reg   <= '0;
                level_reg <= q_data.level;
                cal_reg   <= q_data.cal;
                chk_reg   <= CHK_SEED;
            end
            else if (load)
            begin
                chk_reg <= chk_reg ^ cur_byte;
                if (at_chk)
                    busy_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg + 1'b1;
            end

            if (load)
            begin
                out_valid_reg <= 1'b1;
                byte_out_reg  <= cur_byte;
                idx_out_reg   <= cnt_reg;
                last_out_reg  <= at_chk;
                cal_out_reg   <= cal_reg;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign empty       = !out_valid_reg;
    assign packet_byte = byte_out_reg;
    assign byte_index  = idx_out_reg;
    assign last_byte   = last_out_reg;
    assign calibrating = cal_out_reg;

    `ASSERT_NEXT(a_start_packet, clk, rst_n, q_pop, busy_reg && (cnt_reg == '0))
    `ASSERT_IMPLIES(a_count_range, clk, rst_n, busy_reg, cnt_reg <= IDX_W'(CHK_POS))

endmodule

`default_nettype wire

// File: rtl/level_mapper_packet_framer.sv
// Level mapper and packet framer: one reading in, one 43-byte packet out.
// Path: a reading is classified, mapped by a 7-step divider if needed, queued, then framed.
// New readings are taken while an earlier packet is still framed, unless the queue is full.
// Reset: async active low; min 3000, active max 9000, calibration off, last reading 0.
// Instantiates lmpf_front, lmpf_queue and lmpf_framer; uses lmpf_pkg.
`default_nettype none

module level_mapper_packet_framer
    import lmpf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // reading input
    input  wire logic                  push,
    output logic                       full,
    input  wire logic signed [XW-1:0]  raw_reading,
    // configuration
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [RW-1:0]         cfg_data,
    // packet bytes
    output logic                       empty,
    input  wire logic                  pop,
    output logic [7:0]                 packet_byte,
    output logic [IDX_W-1:0]           byte_index,
    output logic                       last_byte,
    output logic                       calibrating
);

    logic        q_push;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;
    frame_req_t  q_wr_item;
    frame_req_t  q_rd_item;

    lmpf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .raw_reading (raw_reading),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_push      (q_push),
        .q_item      (q_wr_item),
        .q_full      (q_full)
    );

    lmpf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_item),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_item),
        .q_empty (q_empty)
    );

    lmpf_framer u_framer (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_rd_item),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .packet_byte (packet_byte),
        .byte_index  (byte_index),
        .last_byte   (last_byte),
        .calibrating (calibrating)
    );

endmodule

`default_nettype wire
